// ----- sv/mscell_pkg.sv -----
// Shared types, tables and constants of the marching-squares cell triangulator.
package mscell_pkg;

  localparam int unsigned CornerW = 7;
  localparam int unsigned OffW    = 20;
  localparam int unsigned CoordW  = 21;
  localparam int unsigned PtW     = 9;   // cell point coordinate, 0..256
  localparam int unsigned LocW    = 10;  // signed cell-local coordinate
  localparam int unsigned AmtW    = 8;   // interpolation shift, 0..128
  localparam int unsigned VidxW   = 4;   // vertex index, 0..11
  localparam int unsigned StepW   = 3;   // divider step, 0..7
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegMaxValue    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegInterpolate = 2'd1;

  localparam logic [CornerW-1:0] MaxValueReset = 7'd127;
  localparam logic [StepW-1:0]   DivLastStep   = 3'd7;

  localparam logic [VidxW-1:0] CaseLen [16] = '{
    4'd0, 4'd3, 4'd3, 4'd6, 4'd3, 4'd12, 4'd6, 4'd9,
    4'd3, 4'd6, 4'd12, 4'd9, 4'd6, 4'd9, 4'd9, 4'd6
  };

  localparam logic [2:0] CasePts [16][12] = '{
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd5, 3'd6, 3'd7, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd3, 3'd4, 3'd5, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd4, 3'd6, 3'd7, 3'd7, 3'd3, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd1, 3'd2, 3'd3, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd6, 3'd7, 3'd1, 3'd6, 3'd1, 3'd2, 3'd6, 3'd2, 3'd3, 3'd6, 3'd3, 3'd5},
    '{3'd1, 3'd2, 3'd4, 3'd4, 3'd5, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd4, 3'd6, 3'd7, 3'd4, 3'd7, 3'd1, 3'd4, 3'd1, 3'd2, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd1, 3'd7, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd5, 3'd6, 3'd0, 3'd0, 3'd1, 3'd5, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd1, 3'd3, 3'd0, 3'd3, 3'd4, 3'd0, 3'd4, 3'd5, 3'd0, 3'd5, 3'd7},
    '{3'd6, 3'd0, 3'd1, 3'd6, 3'd1, 3'd3, 3'd6, 3'd3, 3'd4, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd2, 3'd3, 3'd3, 3'd7, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd2, 3'd3, 3'd0, 3'd3, 3'd5, 3'd0, 3'd5, 3'd6, 3'd0, 3'd0, 3'd0},
    '{3'd2, 3'd4, 3'd5, 3'd2, 3'd5, 3'd7, 3'd2, 3'd7, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd2, 3'd6, 3'd6, 3'd2, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}
  };

  localparam logic [PtW-1:0] PtX [8] = '{
    9'd0, 9'd0, 9'd0, 9'd128, 9'd256, 9'd256, 9'd256, 9'd128
  };
  localparam logic [PtW-1:0] PtY [8] = '{
    9'd0, 9'd128, 9'd256, 9'd256, 9'd256, 9'd128, 9'd0, 9'd0
  };

  // point index of each corner slot: origin, up, diag, right
  localparam logic [2:0] CornerPt [4] = '{3'd0, 3'd2, 3'd4, 3'd6};

  typedef struct packed {
    logic [CornerW-1:0] max_value;
    logic               interpolate_enable;
  } cfg_t;

  typedef struct packed {
    logic             load;
    logic             div_step;
    logic             div_first;
    logic             emit;
    logic             last;
    logic [VidxW-1:0] vidx;
  } cmd_t;

  typedef struct packed {
    logic             in_empty;
    logic [VidxW-1:0] len;
  } status_t;

endpackage

// ----- sv/marching_squares_cell_triangulator_top.sv -----
// Top level of the marching-squares cell triangulator.
// From the start beat the cell runs through a load step, eight divider steps (one quotient bit
// each), then one vertex beat per cycle for each of the cell's vertices.
// A new cell is taken only once the sequencer is idle again; an all-zero cell gives no vertex beats.
// Each vertex beat shows for one cycle with vert_valid_o high; the receiver cannot stall.
// Reset (rst_ni low, asynchronous) drops any cell in flight; max_value 127, interpolate on.
module marching_squares_cell_triangulator_top import mscell_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // command channel
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic        [CornerW-1:0] corner_origin_i,
  input  logic        [CornerW-1:0] corner_up_i,
  input  logic        [CornerW-1:0] corner_diag_i,
  input  logic        [CornerW-1:0] corner_right_i,
  input  logic signed [OffW-1:0]    offset_x_i,
  input  logic signed [OffW-1:0]    offset_y_i,
  // configuration write channel
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic        [CfgIdxW-1:0] cfg_index_i,
  input  logic        [CornerW-1:0] cfg_data_i,
  // vertex results
  output logic                      vert_valid_o,
  output logic signed [CoordW-1:0]  vert_x_o,
  output logic signed [CoordW-1:0]  vert_y_o,
  output logic                      last_vertex_o
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;
  logic    start_acc;

  // Take configuration beats at any time; a cell in flight keeps the settings
  // captured at its start beat.
  assign cfg_ready_o = 1'b1;

  // Accept a cell only while the sequencer is idle.
  assign start_acc = start_i && !busy_o;

  mscell_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  mscell_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_acc),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // Datapath: hold the cell, run the dividers, register each vertex beat.
  mscell_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .corner_origin_i (corner_origin_i),
    .corner_up_i     (corner_up_i),
    .corner_diag_i   (corner_diag_i),
    .corner_right_i  (corner_right_i),
    .offset_x_i      (offset_x_i),
    .offset_y_i      (offset_y_i),
    .status_o        (status),
    .vert_x_o        (vert_x_o),
    .vert_y_o        (vert_y_o),
    .last_vertex_o   (last_vertex_o),
    .vert_valid_o    (vert_valid_o)
  );

endmodule

// ----- sv/mscell_cfg.sv -----
// Configuration registers of the cell triangulator.
module mscell_cfg import mscell_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [CfgIdxW-1:0] wr_index_i,
  input  logic [CornerW-1:0] wr_data_i,
  output cfg_t               cfg_o
);

  logic [CornerW-1:0] max_value_q;
  logic               interp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_value_q <= MaxValueReset;
      interp_q    <= 1'b1;
    end else if (wr_en_i) begin
      if (wr_index_i == RegMaxValue) begin
        max_value_q <= wr_data_i;
      end
      if (wr_index_i == RegInterpolate) begin
        interp_q <= wr_data_i[0];
      end
    end
  end

  assign cfg_o.max_value          = max_value_q;
  assign cfg_o.interpolate_enable = interp_q;

endmodule

// ----- sv/mscell_ctrl.sv -----
// Sequencer for one cell: divider steps, then one vertex beat per cycle.
module mscell_ctrl import mscell_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o
);

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StEmit
  } state_e;

  state_e           state_q;
  logic [StepW-1:0] step_q;
  logic [VidxW-1:0] vidx_q;
  logic             last_w;

  assign busy_o = (state_q != StIdle);
  assign last_w = (vidx_q == (status_i.len - 4'd1));

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = (state_q == StIdle) && start_i;
    cmd_o.div_step  = (state_q == StDiv);
    cmd_o.div_first = (step_q == '0);
    cmd_o.emit      = (state_q == StEmit);
    cmd_o.last      = last_w;
    cmd_o.vidx      = vidx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
      vidx_q  <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          step_q <= '0;
          vidx_q <= '0;
          if (start_i && !status_i.in_empty) begin
            state_q <= StDiv;
          end
        end
        StDiv: begin
          step_q <= step_q + 3'd1;
          if (step_q == DivLastStep) begin
            state_q <= StEmit;
          end
        end
        StEmit: begin
          vidx_q <= vidx_q + 4'd1;
          if (last_w) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ----- sv/mscell_dp.sv -----
// Datapath: corner capture, four shift dividers and the vertex output register.
module mscell_dp import mscell_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  cmd_t                      cmd_i,
  input  logic        [CornerW-1:0] corner_origin_i,
  input  logic        [CornerW-1:0] corner_up_i,
  input  logic        [CornerW-1:0] corner_diag_i,
  input  logic        [CornerW-1:0] corner_right_i,
  input  logic signed [OffW-1:0]    offset_x_i,
  input  logic signed [OffW-1:0]    offset_y_i,
  output status_t                   status_o,
  output logic signed [CoordW-1:0]  vert_x_o,
  output logic signed [CoordW-1:0]  vert_y_o,
  output logic                      last_vertex_o,
  output logic                      vert_valid_o
);

  logic [CornerW-1:0] corner_in [4];
  logic [CornerW-1:0] corner_q  [4];
  logic [CornerW-1:0] mx_w;
  logic [CornerW-1:0] mx_q;
  logic [3:0]         case_in;
  logic [3:0]         case_q;
  logic               interp_q;
  logic signed [OffW-1:0] off_x_q;
  logic signed [OffW-1:0] off_y_q;

  // divider lanes, one per corner slot
  logic [AmtW-1:0] rem_q [4];
  logic [AmtW-1:0] quo_q [4];

  logic signed [CoordW-1:0] vx_d;
  logic signed [CoordW-1:0] vy_d;
  logic signed [CoordW-1:0] vx_q;
  logic signed [CoordW-1:0] vy_q;
  logic                     last_q;
  logic                     valid_q;

  assign corner_in[0] = corner_origin_i;
  assign corner_in[1] = corner_up_i;
  assign corner_in[2] = corner_diag_i;
  assign corner_in[3] = corner_right_i;

  assign mx_w    = (cfg_i.max_value == '0) ? 7'd1 : cfg_i.max_value;
  assign case_in = {corner_in[0] != '0, corner_in[1] != '0,
                    corner_in[2] != '0, corner_in[3] != '0};

  assign status_o.in_empty = (case_in == '0);
  assign status_o.len      = CaseLen[case_q];

  // Capture the cell and step the restoring dividers: quotient of
  // 128*(mx - c) / mx, top bit first without doubling.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mx_q     <= mx_w;
      case_q   <= case_in;
      interp_q <= cfg_i.interpolate_enable;
      off_x_q  <= offset_x_i;
      off_y_q  <= offset_y_i;
      for (int i = 0; i < 4; i++) begin
        logic [CornerW-1:0] sat;
        sat = (corner_in[i] > mx_w) ? mx_w : corner_in[i];
        corner_q[i] <= sat;
        rem_q[i]    <= {1'b0, mx_w - sat};
        quo_q[i]    <= '0;
      end
    end else if (cmd_i.div_step) begin
      for (int i = 0; i < 4; i++) begin
        logic [AmtW-1:0] t;
        t = cmd_i.div_first ? rem_q[i] : {rem_q[i][AmtW-2:0], 1'b0};
        if (t >= {1'b0, mx_q}) begin
          rem_q[i] <= t - {1'b0, mx_q};
          quo_q[i] <= {quo_q[i][AmtW-2:0], 1'b1};
        end else begin
          rem_q[i] <= t;
          quo_q[i] <= {quo_q[i][AmtW-2:0], 1'b0};
        end
      end
    end
  end

  // Vertex position for the current index.
  always_comb begin
    logic [2:0]            p;
    logic [1:0]            prev;
    logic [1:0]            nxt;
    logic [1:0]            tgt;
    logic [2:0]            tp;
    logic signed [LocW-1:0] x;
    logic signed [LocW-1:0] y;
    logic signed [LocW-1:0] amt;
    p    = CasePts[case_q][cmd_i.vidx];
    prev = 2'((p - 3'd1) >> 1);
    nxt  = 2'((p + 3'd1) >> 1);
    tgt  = (corner_q[nxt] < corner_q[prev]) ? prev : nxt;
    tp   = CornerPt[tgt];
    amt  = signed'({2'b00, quo_q[tgt]});
    x    = signed'({1'b0, PtX[p]});
    y    = signed'({1'b0, PtY[p]});
    if (p[0] && interp_q) begin
      if (PtX[tp] > PtX[p]) begin
        x = x + amt;
      end else if (PtX[tp] < PtX[p]) begin
        x = x - amt;
      end
      if (PtY[tp] > PtY[p]) begin
        y = y + amt;
      end else if (PtY[tp] < PtY[p]) begin
        y = y - amt;
      end
    end
    vx_d = {off_x_q[OffW-1], off_x_q} + {{(CoordW-LocW){x[LocW-1]}}, x};
    vy_d = {off_y_q[OffW-1], off_y_q} + {{(CoordW-LocW){y[LocW-1]}}, y};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      vx_q   <= vx_d;
      vy_q   <= vy_d;
      last_q <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
    end
  end

  assign vert_x_o      = vx_q;
  assign vert_y_o      = vy_q;
  assign last_vertex_o = last_q;
  assign vert_valid_o  = valid_q;

endmodule
